[hdl/dr2h_pkg.sv]
// Shared types, character codes and helpers for the decimal-run to hex-text converter.
package dr2h_pkg;

   // ASCII codes the converter recognizes or produces
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [3:0] NIB_TEN      = 4'd10;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SKIP,
      ST_PREFIX0,
      ST_PREFIXX,
      ST_DIGIT,
      ST_TAIL
   } state_type;

   // Source of the byte loaded into the output register
   typedef enum logic [1:0] {
      EMIT_ZERO,
      EMIT_X,
      EMIT_DIGIT,
      EMIT_TAIL
   } emit_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         capture;  // input transfer this cycle
      logic         skip;     // drop one leading zero nibble
      logic         emit;     // load the output register
      emit_sel_type sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_digit;     // input byte is '0'..'9'
      logic req_eot;       // input byte ends the text
      logic in_run;        // a digit run is open
      logic top_zero;      // leading nibble of the shift register is zero
      logic cnt_one;       // one nibble left
      logic out_free;      // output register can take a byte
      logic tail_pending;  // the closing byte still has to follow
   } sts_type;

   // Upper-case hex character of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < NIB_TEN) begin
         return CHAR_ZERO + {4'd0, nib};
      end
      return CHAR_UPPER_A + {4'd0, nib - NIB_TEN};
   endfunction

endpackage

[hdl/dr2h_req_if.sv]
// Input channel: one text byte and its end-of-text flag.
interface dr2h_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[hdl/dr2h_rsp_if.sv]
// Result channel: one rewritten byte and its last-of-text flag.
interface dr2h_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[hdl/dr2h_ctrl.sv]
// Sequencer for the converter: accepts bytes and steps through the hex emission.
module dr2h_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dr2h_pkg::sts_type sts_i,
   output dr2h_pkg::cmd_type cmd_o
);
   import dr2h_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd_o.capture = 1'b0;
      cmd_o.skip    = 1'b0;
      cmd_o.emit    = 1'b0;
      cmd_o.sel     = EMIT_TAIL;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.capture = 1'b1;
               if (sts_i.req_digit) begin
                  if (sts_i.req_eot) begin
                     state_in = ST_SKIP;
                  end
               end else if (sts_i.in_run) begin
                  state_in = ST_SKIP;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_SKIP: begin
            if (sts_i.top_zero && !sts_i.cnt_one) begin
               cmd_o.skip = 1'b1;
            end else begin
               state_in = ST_PREFIX0;
            end
         end
         ST_PREFIX0: begin
            cmd_o.sel = EMIT_ZERO;
            if (sts_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = ST_PREFIXX;
            end
         end
         ST_PREFIXX: begin
            cmd_o.sel = EMIT_X;
            if (sts_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd_o.sel = EMIT_DIGIT;
            if (sts_i.out_free) begin
               cmd_o.emit = 1'b1;
               if (sts_i.cnt_one) begin
                  state_in = sts_i.tail_pending ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            cmd_o.sel = EMIT_TAIL;
            if (sts_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A skip never runs past the last nibble
   assert property (@(posedge clock) disable iff (reset)
      cmd_o.skip |-> !sts_i.cnt_one)
      else $error("leading-zero skip on the last nibble");

   // After the final hex digit of a text-ending run the sequencer is idle again
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && cmd_o.emit && sts_i.cnt_one && !sts_i.tail_pending)
      |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the last digit");

endmodule

[hdl/dr2h_dpath.sv]
// Datapath: run accumulator, hex shift register, nibble counter and output register.
module dr2h_dpath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  dr2h_pkg::cmd_type cmd_i,
   output dr2h_pkg::sts_type sts_o,
   input  logic [7:0]        in_byte,
   input  logic              end_of_text,
   input  logic              out_ready,
   output logic              out_valid,
   output logic [7:0]        out_byte,
   output logic              out_last
);
   import dr2h_pkg::*;

   localparam int NIB  = (VALUE_WIDTH + 3) / 4;
   localparam int SHW  = NIB * 4;
   localparam int CNTW = $clog2(NIB + 1);

   logic [VALUE_WIDTH-1:0] run_value_ff;
   logic                   in_run_ff;
   logic [SHW-1:0]         shift_ff;
   logic [CNTW-1:0]        cnt_ff;
   logic [7:0]             held_byte_ff;
   logic                   held_eot_ff;
   logic                   held_digit_ff;
   logic                   out_valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   out_last_ff;

   logic                   req_digit;
   logic                   out_free;
   logic                   cnt_one;
   logic [3:0]             top_nib;
   logic [VALUE_WIDTH-1:0] acc_value;
   logic [VALUE_WIDTH-1:0] close_value;
   logic [7:0]             emit_byte;
   logic                   emit_last;

   // Classify the input byte and form value * 10 + digit
   always_comb begin
      req_digit   = in_byte inside {[CHAR_ZERO:CHAR_NINE]};
      acc_value   = (run_value_ff << 3) + (run_value_ff << 1)
                    + VALUE_WIDTH'(in_byte[3:0]);
      close_value = req_digit ? acc_value : run_value_ff;
   end

   assign out_free = !out_valid_ff || out_ready;
   assign cnt_one  = (cnt_ff == CNTW'(1));
   assign top_nib  = shift_ff[SHW-1 -: 4];

   // Run state: accumulate digits, clear when a run closes
   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         in_run_ff    <= 1'b0;
      end else if (cmd_i.capture) begin
         if (req_digit && !end_of_text) begin
            run_value_ff <= acc_value;
            in_run_ff    <= 1'b1;
         end else begin
            run_value_ff <= '0;
            in_run_ff    <= 1'b0;
         end
      end
   end

   // Hold the closing byte; load and advance the hex shift register
   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         held_byte_ff  <= in_byte;
         held_eot_ff   <= end_of_text;
         held_digit_ff <= req_digit;
         shift_ff      <= SHW'(close_value);
         cnt_ff        <= CNTW'(NIB);
      end else if (cmd_i.skip || (cmd_i.emit && cmd_i.sel == EMIT_DIGIT)) begin
         shift_ff <= shift_ff << 4;
         cnt_ff   <= cnt_ff - CNTW'(1);
      end
   end

   // Select the next output byte
   always_comb begin
      emit_byte = held_byte_ff;
      emit_last = 1'b0;
      case (cmd_i.sel)
         EMIT_ZERO:  emit_byte = CHAR_ZERO;
         EMIT_X:     emit_byte = CHAR_X;
         EMIT_DIGIT: begin
            emit_byte = hex_char(top_nib);
            emit_last = cnt_one && held_digit_ff;
         end
         EMIT_TAIL: begin
            emit_byte = held_byte_ff;
            emit_last = held_eot_ff;
         end
         default: begin
            emit_byte = held_byte_ff;
            emit_last = 1'b0;
         end
      endcase
   end

   // Output register: load on emit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cmd_i.emit || (out_valid_ff && !out_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= emit_last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

   // Status to the controller
   always_comb begin
      sts_o.req_digit    = req_digit;
      sts_o.req_eot      = end_of_text;
      sts_o.in_run       = in_run_ff;
      sts_o.top_zero     = (top_nib == 4'd0);
      sts_o.cnt_one      = cnt_one;
      sts_o.out_free     = out_free;
      sts_o.tail_pending = !held_digit_ff;
   end

   // Never overwrite a byte that has not been transferred
   assert property (@(posedge clock) disable iff (reset)
      cmd_i.emit |-> out_free)
      else $error("output register overwritten before transfer");

   // With no run open the accumulator is zero
   assert property (@(posedge clock) disable iff (reset)
      !in_run_ff |-> (run_value_ff == '0))
      else $error("run value not cleared outside a run");

   // The nibble counter never underflows
   assert property (@(posedge clock) disable iff (reset)
      (cmd_i.skip || (cmd_i.emit && cmd_i.sel == EMIT_DIGIT)) |-> (cnt_ff != '0))
      else $error("nibble counter underflow");

endmodule

[hdl/decimal_runs_to_hex_text.sv]
// Top level: rewrites decimal digit runs in a byte stream as 0x-prefixed hex text.
//
//   Channel   Role     Handshake     Payload
//   req_chan  sink     valid/ready   in_byte[7:0], end_of_text
//   rsp_chan  source   valid/ready   out_byte[7:0], out_last
//
// A digit that does not end the text is accumulated and leaves the sequencer
// idle. Closing a run takes the transfer, drops leading zero nibbles from the
// shift register in the skip state (at most NIB-1, NIB = ceil(VALUE_WIDTH/4)),
// leaves the skip state, then emits each byte ("0", "x", digits, and the
// closing byte unless the run ends the text) through the single output register.
// A pass-through byte with no open run goes through the tail state. Output stalls hold the
// sequencer in its emit state; input is taken only while the sequencer is idle.
// Reset is synchronous and clears the open run and the output register.
module decimal_runs_to_hex_text #(
   parameter int VALUE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   dr2h_req_if.sink   req_chan,
   dr2h_rsp_if.source rsp_chan
);
   import dr2h_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dr2h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   dr2h_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .sts_o       (sts),
      .in_byte     (req_chan.in_byte),
      .end_of_text (req_chan.end_of_text),
      .out_ready   (rsp_chan.ready),
      .out_valid   (rsp_chan.valid),
      .out_byte    (rsp_chan.out_byte),
      .out_last    (rsp_chan.out_last)
   );

endmodule

[dv/decimal_runs_to_hex_text_test.sv]
// Testbench for the decimal-run to hex-text converter: random texts checked against a predictor.
`timescale 1ns / 1ps

// Predicts the rewritten text and checks each output transfer in order
class hex_text_board;
   localparam int RUN_WIDTH = 32;
   localparam int RUN_NIBS  = (RUN_WIDTH + 3) / 4;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
   } out_char_type;

   out_char_type           hex_text_due[$];
   logic [RUN_WIDTH-1:0]   run_total;
   logic                   run_open;
   int                     mismatches;

   function new();
      run_total  = '0;
      run_open   = 1'b0;
      mismatches = 0;
   endfunction

   // Queue one expected output byte
   function void push_char(logic [7:0] text_char, logic last);
      out_char_type entry;
      entry.text_char = text_char;
      entry.last      = last;
      hex_text_due.push_back(entry);
   endfunction

   // Queue "0x" and the hex digits of the open run; mark tags the final digit
   function void push_hex(logic mark);
      int         top;
      logic [3:0] nib;
      top = 0;
      for (int k = 0; k < RUN_NIBS; k++) begin
         if (run_total[4*k +: 4] != 4'd0) top = k;
      end
      push_char(dr2h_pkg::CHAR_ZERO, 1'b0);
      push_char(dr2h_pkg::CHAR_X, 1'b0);
      for (int k = top; k >= 0; k--) begin
         nib = run_total[4*k +: 4];
         if (nib < 4'd10) begin
            push_char(dr2h_pkg::CHAR_ZERO + 8'(nib), (k == 0) && mark);
         end else begin
            push_char(dr2h_pkg::CHAR_UPPER_A + 8'(nib - 4'd10), (k == 0) && mark);
         end
      end
   endfunction

   // Note one accepted input transfer and predict what it emits
   function void note_text_char(logic [7:0] text_char, logic eot);
      if (text_char >= dr2h_pkg::CHAR_ZERO && text_char <= dr2h_pkg::CHAR_NINE) begin
         run_total = run_total * RUN_WIDTH'(10) + RUN_WIDTH'(text_char[3:0]);
         run_open  = 1'b1;
         if (eot) begin
            push_hex(1'b1);
            run_total = '0;
            run_open  = 1'b0;
         end
      end else begin
         if (run_open) push_hex(1'b0);
         push_char(text_char, eot);
         run_total = '0;
         run_open  = 1'b0;
      end
   endfunction

   // Compare one output transfer with the oldest expected byte
   function void check_out_char(logic [7:0] text_char, logic last);
      out_char_type want;
      if (hex_text_due.size() == 0) begin
         $display("%0t: unexpected output byte %h last %b", $time, text_char, last);
         mismatches++;
         return;
      end
      want = hex_text_due.pop_front();
      if (want.text_char !== text_char) begin
         $display("%0t: out_byte expected %h actual %h", $time, want.text_char, text_char);
         mismatches++;
      end
      if (want.last !== last) begin
         $display("%0t: out_last expected %b actual %b (byte %h)",
                  $time, want.last, last, text_char);
         mismatches++;
      end
   endfunction
endclass

module decimal_runs_to_hex_text_test;
   import dr2h_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int          PHASE_CHARS  = 118;
   localparam int          SETTLE_TICKS = 40;

   logic clock = 1'b0;
   logic reset;

   dr2h_req_if req_chan ();
   dr2h_rsp_if rsp_chan ();

   decimal_runs_to_hex_text dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hex_text_board board;
   int            send_idle_pct;
   int            rsp_stall_pct;
   int unsigned   cycle_count = 0;
   string         max_run = "4294967295";

   // Free-running clock, 8 ns period
   always #4 clock = ~clock;

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes outstanding", $time, board.hex_text_due.size());
         $display("status: fail");
         $finish;
      end
   end

   // Stall the output side at random
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every output transfer
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_out_char(rsp_chan.out_byte, rsp_chan.out_last);
      end
   end

   // Offer one byte after a random gap; return at the falling edge after its transfer
   task automatic send_text_char(input logic [7:0] text_char, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.in_byte     <= text_char;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_text_char(text_char, eot);
      @(negedge clock);
   endtask

   // Hold the input idle until every expected byte has come out
   task automatic drain_text();
      req_chan.valid <= 1'b0;
      while (board.hex_text_due.size() != 0) @(negedge clock);
   endtask

   // Pick a byte that is not a decimal digit
   function automatic logic [7:0] pick_plain_char();
      logic [7:0] text_char;
      text_char = 8'($urandom_range(255));
      while (text_char >= CHAR_ZERO && text_char <= CHAR_NINE) begin
         text_char = 8'($urandom_range(255));
      end
      return text_char;
   endfunction

   // Send digit runs of mixed length separated by plain bytes, with random text ends
   task automatic send_random_texts(input int char_goal);
      int   sent;
      int   run_len;
      int   pick;
      logic eot;
      sent = 0;
      while (sent < char_goal) begin
         pick = $urandom_range(19);
         if (pick == 0) run_len = 0;
         else if (pick < 11) run_len = $urandom_range(3, 1);
         else if (pick < 16) run_len = $urandom_range(9, 4);
         else run_len = $urandom_range(14, 10);
         eot = 1'b0;
         for (int i = 0; i < run_len; i++) begin
            eot = (i == run_len - 1) && ($urandom_range(5) == 0);
            send_text_char(CHAR_ZERO + 8'($urandom_range(9)), eot);
            sent++;
         end
         if (!eot) begin
            send_text_char(pick_plain_char(), $urandom_range(4) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      board                = new();
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.in_byte     = 8'h00;
      req_chan.end_of_text = 1'b0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero run, boundary bytes, run closed at end of text, NUL, 0xFF, widest value
      send_text_char("0", 1'b0);
      send_text_char(":", 1'b0);
      send_text_char("9", 1'b1);
      send_text_char(8'h00, 1'b0);
      send_text_char("/", 1'b1);
      send_text_char("7", 1'b0);
      send_text_char(8'hFF, 1'b1);
      for (int i = 0; i < max_run.len(); i++) begin
         send_text_char(max_run[i], i == max_run.len() - 1);
      end
      drain_text();

      // Random texts under each idling mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         send_random_texts(PHASE_CHARS);
         drain_text();
      end

      // Let any stray output show up before the verdict
      repeat (SETTLE_TICKS) @(posedge clock);
      if (board.hex_text_due.size() != 0) begin
         $display("%0t: %0d expected bytes never came out", $time, board.hex_text_due.size());
         board.mismatches++;
      end
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

[files.f]
hdl/dr2h_pkg.sv
hdl/dr2h_req_if.sv
hdl/dr2h_rsp_if.sv
hdl/dr2h_ctrl.sv
hdl/dr2h_dpath.sv
hdl/decimal_runs_to_hex_text.sv
dv/decimal_runs_to_hex_text_test.sv
